### sv/three_axis_biquad_filter_macros.svh
// assertion macros shared by the three-axis biquad filter rtl
// no dependencies; included by the modules that carry assertions
`ifndef THREE_AXIS_BIQUAD_FILTER_MACROS_SVH
`define THREE_AXIS_BIQUAD_FILTER_MACROS_SVH

// same-cycle implication, muted during reset
`define TABF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tabf assertion failed: same-cycle implication");

// next-cycle implication, muted during reset
`define TABF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tabf assertion failed: next-cycle implication");

`endif

### sv/tabf_pkg.sv
// types, constants and microcode program of the three-axis biquad filter
// no dependencies; imported by every module of the block
`default_nettype none

package tabf_pkg;

  localparam int SAMPLE_WIDTH_DEF   = 16;
  localparam int COEF_FRAC_BITS_DEF = 16;
  localparam int STATE_WIDTH_DEF    = 40;
  localparam int COEF_W             = 20;
  localparam int NUM_AXES           = 3;
  localparam int NUM_COEFS          = 5;
  localparam int AXIS_W             = 2;
  localparam int CFG_INDEX_W        = 3;
  localparam int PC_W               = 4;
  localparam int UCODE_LEN          = 9;

  // coefficient select, also the configuration register index
  typedef enum logic [CFG_INDEX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B1 = 3'd1,
    COEF_B2 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4
  } coef_sel_t;

  typedef enum logic {
    OPND_X = 1'b0,
    OPND_Y = 1'b1
  } opnd_sel_t;

  typedef enum logic [2:0] {
    ALU_NOP    = 3'd0,
    ALU_ACC_D1 = 3'd1,
    ALU_ROUND  = 3'd2,
    ALU_LOAD   = 3'd3,
    ALU_SUB    = 3'd4,
    ALU_UPD_D1 = 3'd5,
    ALU_UPD_D2 = 3'd6
  } alu_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT     = 2'd0,
    SEQ_JMP_AXIS = 2'd1,
    SEQ_FINISH   = 2'd2
  } seq_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } seq_state_t;

  typedef struct packed {
    logic            mul_en;
    coef_sel_t       coef_sel;
    opnd_sel_t       opnd_sel;
    alu_op_t         alu_op;
    seq_op_t         seq_op;
    logic [PC_W-1:0] target;
  } ucode_t;

  // control from sequencer to datapath
  typedef struct packed {
    logic              load_in;
    logic              load_out;
    logic              mul_en;
    coef_sel_t         coef_sel;
    opnd_sel_t         opnd_sel;
    alu_op_t           alu_op;
    logic [AXIS_W-1:0] axis;
  } dp_ctl_t;

  // one axis takes words 0..7, word 7 loops over the axes, word 8 hands off
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{mul_en: 1'b0, coef_sel: COEF_B0, opnd_sel: OPND_X, alu_op: ALU_NOP,
          seq_op: SEQ_NEXT, target: '0};
    case (pc)
      4'd0: begin
        w.mul_en = 1'b1; w.coef_sel = COEF_B0; w.opnd_sel = OPND_X;
      end
      4'd1: begin
        w.alu_op = ALU_ACC_D1;
      end
      4'd2: begin
        w.alu_op = ALU_ROUND;
        w.mul_en = 1'b1; w.coef_sel = COEF_B1; w.opnd_sel = OPND_X;
      end
      4'd3: begin
        w.alu_op = ALU_LOAD;
        w.mul_en = 1'b1; w.coef_sel = COEF_A1; w.opnd_sel = OPND_Y;
      end
      4'd4: begin
        w.alu_op = ALU_SUB;
        w.mul_en = 1'b1; w.coef_sel = COEF_B2; w.opnd_sel = OPND_X;
      end
      4'd5: begin
        w.alu_op = ALU_UPD_D1;
      end
      4'd6: begin
        w.alu_op = ALU_LOAD;
        w.mul_en = 1'b1; w.coef_sel = COEF_A2; w.opnd_sel = OPND_Y;
      end
      4'd7: begin
        w.alu_op = ALU_UPD_D2;
        w.seq_op = SEQ_JMP_AXIS; w.target = '0;
      end
      default: begin
        w.seq_op = SEQ_FINISH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### sv/three_axis_biquad_filter.sv
// top level of the three-axis biquad filter (transposed direct form ii)
// depends on tabf_pkg, tabf_sequencer and tabf_datapath
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_ready   | in_sample_x/y/z, in_block_end
//   out     | out_valid / out_ready | out_filtered_x/y/z, out_block_end_out
//   cfg     | cfg_valid / cfg_ready | cfg_index (coef b0 b1 b2 a1 a2), cfg_data
//
// each item is accepted in the idle state, then runs eight microcode steps per axis on
// the single shared multiplier and adder, and one hand-off step to the output register
// synchronous active-low reset clears coefficients, delay words and sequencer state
// the next item is accepted while the last result waits; only the hand-off step stalls
// on a full output register, and cfg writes are taken whenever no item is in progress
`default_nettype none

module three_axis_biquad_filter #(
  parameter int SAMPLE_WIDTH   = tabf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = tabf_pkg::COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = tabf_pkg::STATE_WIDTH_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  // input items
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire signed [SAMPLE_WIDTH-1:0]          in_sample_x,
  input  wire signed [SAMPLE_WIDTH-1:0]          in_sample_y,
  input  wire signed [SAMPLE_WIDTH-1:0]          in_sample_z,
  input  wire                                    in_block_end,
  // result items
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]         out_filtered_x,
  output logic signed [SAMPLE_WIDTH-1:0]         out_filtered_y,
  output logic signed [SAMPLE_WIDTH-1:0]         out_filtered_z,
  output logic                                   out_block_end_out,
  // coefficient writes
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire        [tabf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire signed [tabf_pkg::COEF_W-1:0]      cfg_data
);
  import tabf_pkg::*;

  dp_ctl_t ctl;
  logic    busy;
  logic    cfg_wr;

  // coefficients only move between items, so the delay clear never races the program
  assign cfg_ready = !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;

  tabf_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .busy      (busy),
    .ctl       (ctl)
  );

  // shared multiplier, saturating adder, coefficient and delay registers
  tabf_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .STATE_WIDTH    (STATE_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .cfg_wr            (cfg_wr),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sample_x       (in_sample_x),
    .in_sample_y       (in_sample_y),
    .in_sample_z       (in_sample_z),
    .in_block_end      (in_block_end),
    .out_filtered_x    (out_filtered_x),
    .out_filtered_y    (out_filtered_y),
    .out_filtered_z    (out_filtered_z),
    .out_block_end_out (out_block_end_out)
  );

endmodule

`default_nettype wire

### sv/tabf_datapath.sv
// datapath of the biquad filter: coefficients, delay words, one multiplier, one adder
// depends on tabf_pkg; driven by tabf_sequencer through a dp_ctl_t word
`default_nettype none

module tabf_datapath #(
  parameter int SAMPLE_WIDTH   = tabf_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = tabf_pkg::COEF_FRAC_BITS_DEF,
  parameter int STATE_WIDTH    = tabf_pkg::STATE_WIDTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  tabf_pkg::dp_ctl_t                     ctl,
  input  wire                                   cfg_wr,
  input  wire        [tabf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire signed [tabf_pkg::COEF_W-1:0]     cfg_data,
  input  wire signed [SAMPLE_WIDTH-1:0]         in_sample_x,
  input  wire signed [SAMPLE_WIDTH-1:0]         in_sample_y,
  input  wire signed [SAMPLE_WIDTH-1:0]         in_sample_z,
  input  wire                                   in_block_end,
  output logic signed [SAMPLE_WIDTH-1:0]        out_filtered_x,
  output logic signed [SAMPLE_WIDTH-1:0]        out_filtered_y,
  output logic signed [SAMPLE_WIDTH-1:0]        out_filtered_z,
  output logic                                  out_block_end_out
);
  import tabf_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_WIDTH;
  localparam int ACC_W  = (STATE_WIDTH > PROD_W + 1) ? STATE_WIDTH : PROD_W + 1;
  localparam int SUM_W  = ACC_W + 1;
  localparam int RW     = (STATE_WIDTH > SAMPLE_WIDTH) ? STATE_WIDTH : SAMPLE_WIDTH;

  localparam logic signed [SUM_W-1:0] ST_MAX = SUM_W'({1'b0, {(STATE_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [RW-1:0]    SM_MAX = RW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic signed [RW-1:0]    SM_MIN = ~SM_MAX;

  function automatic logic signed [STATE_WIDTH-1:0] sat_state(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > ST_MAX) c = ST_MAX;
    else if (v < ST_MIN) c = ST_MIN;
    return STATE_WIDTH'(c);
  endfunction

  logic signed [COEF_W-1:0]       coef_r [NUM_COEFS];
  logic signed [COEF_W-1:0]       coef_nxt [NUM_COEFS];
  logic signed [STATE_WIDTH-1:0]  d1_r [NUM_AXES];
  logic signed [STATE_WIDTH-1:0]  d1_nxt [NUM_AXES];
  logic signed [STATE_WIDTH-1:0]  d2_r [NUM_AXES];
  logic signed [STATE_WIDTH-1:0]  d2_nxt [NUM_AXES];
  logic signed [SAMPLE_WIDTH-1:0] x_r [NUM_AXES];
  logic signed [SAMPLE_WIDTH-1:0] x_nxt [NUM_AXES];
  logic signed [SAMPLE_WIDTH-1:0] y_r [NUM_AXES];
  logic signed [SAMPLE_WIDTH-1:0] y_nxt [NUM_AXES];
  logic                           be_r, be_nxt;
  logic signed [PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [ACC_W-1:0]        t_r, t_nxt;
  logic signed [SAMPLE_WIDTH-1:0] ofx_r, ofx_nxt, ofy_r, ofy_nxt, ofz_r, ofz_nxt;
  logic                           obe_r, obe_nxt;

  logic signed [COEF_W-1:0]       mul_a;
  logic signed [SAMPLE_WIDTH-1:0] mul_b;
  logic signed [SUM_W-1:0]        prod_ext, t_ext, d1_ext, d2_ext, rnd_sum;
  logic signed [STATE_WIDTH-1:0]  rnd_sat;
  logic signed [RW-1:0]           rnd_shr;
  logic signed [SAMPLE_WIDTH-1:0] rnd_y;

  // operand selection for the shared multiplier
  always_comb begin
    unique case (ctl.coef_sel)
      COEF_B0: mul_a = coef_r[0];
      COEF_B1: mul_a = coef_r[1];
      COEF_B2: mul_a = coef_r[2];
      COEF_A1: mul_a = coef_r[3];
      COEF_A2: mul_a = coef_r[4];
      default: mul_a = '0;
    endcase
    mul_b = (ctl.opnd_sel == OPND_Y) ? y_r[ctl.axis] : x_r[ctl.axis];
  end

  // round half up, saturate, then clamp to the sample range
  always_comb begin
    prod_ext = SUM_W'(prod_r);
    t_ext    = SUM_W'(t_r);
    d1_ext   = SUM_W'(d1_r[ctl.axis]);
    d2_ext   = SUM_W'(d2_r[ctl.axis]);
    rnd_sum  = t_ext + HALF;
    rnd_sat  = sat_state(rnd_sum);
    rnd_shr  = RW'(rnd_sat) >>> COEF_FRAC_BITS;
    if (rnd_shr > SM_MAX) rnd_y = SAMPLE_WIDTH'(SM_MAX);
    else if (rnd_shr < SM_MIN) rnd_y = SAMPLE_WIDTH'(SM_MIN);
    else rnd_y = SAMPLE_WIDTH'(rnd_shr);
  end

  always_comb begin
    coef_nxt = coef_r;
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    be_nxt   = be_r;
    prod_nxt = prod_r;
    t_nxt    = t_r;
    ofx_nxt  = ofx_r;
    ofy_nxt  = ofy_r;
    ofz_nxt  = ofz_r;
    obe_nxt  = obe_r;

    if (ctl.load_in) begin
      x_nxt[0] = in_sample_x;
      x_nxt[1] = in_sample_y;
      x_nxt[2] = in_sample_z;
      be_nxt   = in_block_end;
    end

    if (ctl.mul_en) prod_nxt = mul_a * mul_b;

    case (ctl.alu_op)
      ALU_ACC_D1: t_nxt = ACC_W'(sat_state(prod_ext + d1_ext));
      ALU_ROUND:  y_nxt[ctl.axis] = rnd_y;
      ALU_LOAD:   t_nxt = ACC_W'(prod_r);
      ALU_SUB:    t_nxt = ACC_W'(t_ext - prod_ext);
      ALU_UPD_D1: d1_nxt[ctl.axis] = sat_state(t_ext + d2_ext);
      ALU_UPD_D2: d2_nxt[ctl.axis] = sat_state(t_ext - prod_ext);
      default: ;
    endcase

    if (ctl.load_out) begin
      ofx_nxt = y_r[0];
      ofy_nxt = y_r[1];
      ofz_nxt = y_r[2];
      obe_nxt = be_r;
    end

    // a coefficient write clears every delay word
    if (cfg_wr) begin
      unique case (coef_sel_t'(cfg_index))
        COEF_B0: coef_nxt[0] = cfg_data;
        COEF_B1: coef_nxt[1] = cfg_data;
        COEF_B2: coef_nxt[2] = cfg_data;
        COEF_A1: coef_nxt[3] = cfg_data;
        COEF_A2: coef_nxt[4] = cfg_data;
        default: ;
      endcase
      if (cfg_index < CFG_INDEX_W'(NUM_COEFS)) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          d1_nxt[i] = '0;
          d2_nxt[i] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFS; i++) coef_r[i] <= '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        d1_r[i] <= '0;
        d2_r[i] <= '0;
      end
    end else begin
      coef_r <= coef_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    be_r   <= be_nxt;
    prod_r <= prod_nxt;
    t_r    <= t_nxt;
    ofx_r  <= ofx_nxt;
    ofy_r  <= ofy_nxt;
    ofz_r  <= ofz_nxt;
    obe_r  <= obe_nxt;
  end

  assign out_filtered_x    = ofx_r;
  assign out_filtered_y    = ofy_r;
  assign out_filtered_z    = ofz_r;
  assign out_block_end_out = obe_r;

endmodule

`default_nettype wire

### sv/tabf_sequencer.sv
// microcode sequencer: step counter, axis loop, handshakes and output valid
// depends on tabf_pkg and three_axis_biquad_filter_macros.svh
`default_nettype none
`include "three_axis_biquad_filter_macros.svh"

module tabf_sequencer (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               busy,
  output tabf_pkg::dp_ctl_t  ctl
);
  import tabf_pkg::*;

  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);

  seq_state_t        state_r, state_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [AXIS_W-1:0] axis_r, axis_nxt;
  logic              out_valid_r, out_valid_nxt;
  ucode_t            word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      axis_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    word          = ucode_rom(pc_r);
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;
    ctl.axis      = axis_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_nxt   = ST_RUN;
          pc_nxt      = '0;
          axis_nxt    = '0;
        end
      end
      ST_RUN: begin
        ctl.mul_en   = word.mul_en;
        ctl.coef_sel = word.coef_sel;
        ctl.opnd_sel = word.opnd_sel;
        ctl.alu_op   = word.alu_op;
        unique case (word.seq_op)
          SEQ_NEXT: pc_nxt = PC_W'(pc_r + 1'b1);
          SEQ_JMP_AXIS: begin
            if (axis_r != LAST_AXIS) begin
              pc_nxt   = word.target;
              axis_nxt = AXIS_W'(axis_r + 1'b1);
            end else begin
              pc_nxt = PC_W'(pc_r + 1'b1);
            end
          end
          SEQ_FINISH: begin
            // wait here while the previous result is still unclaimed
            if (!out_valid_r || out_ready) begin
              ctl.load_out  = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign busy      = (state_r == ST_RUN);
  assign out_valid = out_valid_r;

  `TABF_ASSERT_NXT(a_start_at_top, clk, rst_n, in_valid && in_ready, state_r == ST_RUN && pc_r == '0 && axis_r == '0)
  `TABF_ASSERT_IMP(a_pc_in_program, clk, rst_n, state_r == ST_RUN, pc_r < PC_W'(UCODE_LEN))
  `TABF_ASSERT_IMP(a_axis_in_range, clk, rst_n, state_r == ST_RUN, axis_r <= LAST_AXIS)
  `TABF_ASSERT_IMP(a_no_overwrite, clk, rst_n, ctl.load_out, !out_valid_r || out_ready)

endmodule

`default_nettype wire

### test/three_axis_biquad_filter_checker.sv
// result checker for the three-axis biquad filter: watches all three channels,
// predicts each filtered triple and compares it with what the block returns
// depends on tabf_pkg for widths and coefficient register codes
`timescale 1ns / 1ps

module three_axis_biquad_filter_checker
  import tabf_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  wire signed [SAMPLE_WIDTH_DEF-1:0] in_sample_x,
  input  wire signed [SAMPLE_WIDTH_DEF-1:0] in_sample_y,
  input  wire signed [SAMPLE_WIDTH_DEF-1:0] in_sample_z,
  input  wire                          in_block_end,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  wire signed [SAMPLE_WIDTH_DEF-1:0] out_filtered_x,
  input  wire signed [SAMPLE_WIDTH_DEF-1:0] out_filtered_y,
  input  wire signed [SAMPLE_WIDTH_DEF-1:0] out_filtered_z,
  input  wire                          out_block_end_out,
  input  wire                          cfg_valid,
  input  wire                          cfg_ready,
  input  wire        [CFG_INDEX_W-1:0] cfg_index,
  input  wire signed [COEF_W-1:0]      cfg_data,
  output int                           fail_count,
  output int                           pending
);

  localparam int SW  = SAMPLE_WIDTH_DEF;
  localparam int FB  = COEF_FRAC_BITS_DEF;
  localparam int STW = STATE_WIDTH_DEF;

  localparam longint STATE_HI   = (longint'(1) <<< (STW - 1)) - 1;
  localparam longint STATE_LO   = -STATE_HI - 1;
  localparam longint SAMPLE_HI  = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAMPLE_LO  = -SAMPLE_HI - 1;
  localparam longint ROUND_HALF = longint'(1) <<< (FB - 1);

  typedef struct packed {
    logic signed [SW-1:0] filtered_x;
    logic signed [SW-1:0] filtered_y;
    logic signed [SW-1:0] filtered_z;
    logic                 block_end_out;
  } filtered_triple_t;

  logic signed [COEF_W-1:0] coef [NUM_COEFS];
  logic signed [STW-1:0]    delay_first  [NUM_AXES];
  logic signed [STW-1:0]    delay_second [NUM_AXES];
  filtered_triple_t         expected_triples [$];

  function automatic longint clamp_state(input longint v);
    if (v > STATE_HI) return STATE_HI;
    if (v < STATE_LO) return STATE_LO;
    return v;
  endfunction

  function automatic void clear_delays();
    for (int a = 0; a < NUM_AXES; a++) begin
      delay_first[a]  = '0;
      delay_second[a] = '0;
    end
  endfunction

  // one transposed direct form ii step for one axis, updates that axis' delays
  function automatic logic signed [SW-1:0] filter_sample(input int axis,
                                                         input logic signed [SW-1:0] sample);
    longint x, y, acc, b0, b1, b2, a1, a2;
    x   = longint'(sample);
    b0  = longint'(coef[COEF_B0]);
    b1  = longint'(coef[COEF_B1]);
    b2  = longint'(coef[COEF_B2]);
    a1  = longint'(coef[COEF_A1]);
    a2  = longint'(coef[COEF_A2]);
    acc = clamp_state(b0 * x + longint'(delay_first[axis]));
    acc = clamp_state(acc + ROUND_HALF);
    y   = acc >>> FB;
    if (y > SAMPLE_HI) y = SAMPLE_HI;
    if (y < SAMPLE_LO) y = SAMPLE_LO;
    delay_first[axis]  = STW'(clamp_state(b1 * x - a1 * y + longint'(delay_second[axis])));
    delay_second[axis] = STW'(clamp_state(b2 * x - a2 * y));
    return SW'(y);
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin : monitor
    filtered_triple_t want;
    if (!rst_n) begin
      for (int k = 0; k < NUM_COEFS; k++) coef[k] = '0;
      clear_delays();
      expected_triples.delete();
    end else begin
      // results first: nothing accepted at this edge can already be on the output
      if (out_valid && out_ready) begin
        if (expected_triples.size() == 0) begin
          $error("result item with no item outstanding");
          fail_count++;
        end else begin
          want = expected_triples.pop_front();
          compare_field("filtered_x", longint'(want.filtered_x), longint'(out_filtered_x));
          compare_field("filtered_y", longint'(want.filtered_y), longint'(out_filtered_y));
          compare_field("filtered_z", longint'(want.filtered_z), longint'(out_filtered_z));
          compare_field("block_end_out", longint'(want.block_end_out),
                        longint'(out_block_end_out));
        end
      end
      if (cfg_valid && cfg_ready) begin
        // an index past the last coefficient leaves coefficients and delays alone
        case (cfg_index) inside
          COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2: begin
            coef[cfg_index] = cfg_data;
            clear_delays();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want.filtered_x    = filter_sample(0, in_sample_x);
        want.filtered_y    = filter_sample(1, in_sample_y);
        want.filtered_z    = filter_sample(2, in_sample_z);
        want.block_end_out = in_block_end;
        expected_triples.push_back(want);
      end
    end
    pending = expected_triples.size();
  end

endmodule

### test/testbench.sv
// top of the three-axis biquad filter testbench: clock, reset, stimulus and verdict
// depends on tabf_pkg, three_axis_biquad_filter and three_axis_biquad_filter_checker
`timescale 1ns / 1ps

module testbench;
  import tabf_pkg::*;

  localparam int SW           = SAMPLE_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1550;
  localparam int LONG_HOLD    = 300;   // receiver hold-off that fills the block up
  localparam int IDLE_LIMIT   = 4000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 40;    // a bit more than one item through the block

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << COEF_FRAC_BITS_DEF);
  localparam logic signed [COEF_W-1:0] COEF_HALF = COEF_W'(1 << (COEF_FRAC_BITS_DEF - 1));
  localparam logic [CFG_INDEX_W-1:0]   FIRST_UNUSED_INDEX = CFG_INDEX_W'(NUM_COEFS);
  localparam logic [CFG_INDEX_W-1:0]   LAST_UNUSED_INDEX  = {CFG_INDEX_W{1'b1}};

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [SW-1:0]   in_sample_x;
  logic signed [SW-1:0]   in_sample_y;
  logic signed [SW-1:0]   in_sample_z;
  logic                   in_block_end;
  logic                   out_valid;
  logic                   out_ready;
  logic signed [SW-1:0]   out_filtered_x;
  logic signed [SW-1:0]   out_filtered_y;
  logic signed [SW-1:0]   out_filtered_z;
  logic                   out_block_end_out;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic signed [COEF_W-1:0] cfg_data;

  int   chk_fails;
  int   chk_pending;
  int   items_sent;
  bit   gaps_on;
  logic hold_req;

  three_axis_biquad_filter uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .in_sample_z      (in_sample_z),
    .in_block_end     (in_block_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filtered_x   (out_filtered_x),
    .out_filtered_y   (out_filtered_y),
    .out_filtered_z   (out_filtered_z),
    .out_block_end_out(out_block_end_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  three_axis_biquad_filter_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .in_sample_z      (in_sample_z),
    .in_block_end     (in_block_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filtered_x   (out_filtered_x),
    .out_filtered_y   (out_filtered_y),
    .out_filtered_z   (out_filtered_z),
    .out_block_end_out(out_block_end_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (chk_fails),
    .pending          (chk_pending)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // offer one item after an optional gap, hold it until taken, then drop valid
  // called and left at a falling edge
  task automatic send_item(input logic signed [SW-1:0] sx, input logic signed [SW-1:0] sy,
                           input logic signed [SW-1:0] sz, input logic be);
    int gap;
    int r;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r < 60) gap = 0;
      else if (r < 93) gap = $urandom_range(1, 4);
      else gap = $urandom_range(15, 60);
      repeat (gap) @(negedge clk);
    end
    in_sample_x  = sx;
    in_sample_y  = sy;
    in_sample_z  = sz;
    in_block_end = be;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
  endtask

  // register writes only go out once every item in flight has come back
  task automatic write_coef(input logic [CFG_INDEX_W-1:0] idx,
                            input logic signed [COEF_W-1:0] data);
    while (chk_pending != 0) @(negedge clk);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_all(input logic signed [COEF_W-1:0] b0,
                             input logic signed [COEF_W-1:0] b1,
                             input logic signed [COEF_W-1:0] b2,
                             input logic signed [COEF_W-1:0] a1,
                             input logic signed [COEF_W-1:0] a2);
    write_coef(COEF_B0, b0);
    write_coef(COEF_B1, b1);
    write_coef(COEF_B2, b2);
    write_coef(COEF_A1, a1);
    write_coef(COEF_A2, a2);
  endtask

  // new coefficients for a random phase, in one of several flavors
  task automatic program_random_phase();
    logic signed [COEF_W-1:0] set [NUM_COEFS];
    int style;
    int recipe;
    int off;
    int pick;
    style  = $urandom_range(0, 3);
    recipe = $urandom_range(0, 3);
    for (int k = 0; k < NUM_COEFS; k++) begin
      case (style)
        0: set[k] = COEF_W'($urandom);                              // anything, mostly unstable
        1: set[k] = '0;
        2: set[k] = COEF_W'($urandom_range(0, 16383)) - 20'sd8192;  // small taps
        default: begin
          pick = $urandom_range(0, 4);
          case (pick)
            0: set[k] = COEF_MAX;
            1: set[k] = COEF_MIN;
            2: set[k] = COEF_ONE;
            3: set[k] = -COEF_ONE;
            default: set[k] = '0;
          endcase
        end
      endcase
    end
    if (style == 1) begin
      // realistic filters: low pass, high pass, near-oscillating resonator, notch
      case (recipe)
        0: begin
          set[0] = COEF_W'(4426);   set[1] = COEF_W'(8852);   set[2] = COEF_W'(4426);
          set[3] = COEF_W'(-74907); set[4] = COEF_W'(27054);
        end
        1: begin
          set[0] = COEF_W'(41872);  set[1] = COEF_W'(-83744); set[2] = COEF_W'(41872);
          set[3] = COEF_W'(-74907); set[4] = COEF_W'(27054);
        end
        2: begin
          set[0] = COEF_W'(65536);   set[1] = '0;              set[2] = '0;
          set[3] = COEF_W'(-124518); set[4] = COEF_W'(63897);
        end
        default: begin
          set[0] = COEF_W'(65536);   set[1] = COEF_W'(-106044); set[2] = COEF_W'(65536);
          set[3] = COEF_W'(-100740); set[4] = COEF_W'(61604);
        end
      endcase
      for (int k = 0; k < NUM_COEFS; k++)
        set[k] = set[k] + COEF_W'($urandom_range(0, 510)) - 20'sd255;
    end
    off = $urandom_range(0, NUM_COEFS - 1);
    if ($urandom_range(0, 4) == 0) begin
      // only one register changes, the rest stay from the last phase
      write_coef(coef_sel_t'(off), set[off]);
    end else begin
      for (int k = 0; k < NUM_COEFS; k++)
        write_coef(coef_sel_t'((k + off) % NUM_COEFS), set[(k + off) % NUM_COEFS]);
    end
    if ($urandom_range(0, 3) == 0)
      write_coef(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_INDEX, LAST_UNUSED_INDEX)),
                 COEF_W'($urandom));
  endtask

  // watchdog: any handshake restarts the count
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("three_axis_biquad_filter verification failed");
    $finish;
  end

  // receiver: random ready pattern, plus one long hold-off on request
  initial begin : receiver
    int   run_left;
    int   r;
    bit   hold_done;
    logic ready_val;
    run_left  = 0;
    hold_done = 1'b0;
    ready_val = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        // block fills up while the sender keeps offering items
        hold_done = 1'b1;
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          ready_val = 1'b1; run_left = $urandom_range(1, 20);
        end else if (r < 70) begin
          ready_val = 1'b1; run_left = $urandom_range(40, 120);   // no stalls for a while
        end else if (r < 93) begin
          ready_val = 1'b0; run_left = $urandom_range(1, 4);
        end else begin
          ready_val = 1'b0; run_left = $urandom_range(20, 80);
        end
      end
      out_ready = ready_val;
      run_left--;
    end
  end

  // main stimulus
  initial begin : stimulus
    logic signed [SW-1:0] held [NUM_AXES];
    logic signed [SW-1:0] s [NUM_AXES];
    int   phase_len;
    int   samp_mode;
    int   blk_left;
    int   target;
    logic be;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_x  = '0;
    in_sample_y  = '0;
    in_sample_z  = '0;
    in_block_end = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    hold_req     = 1'b0;
    items_sent   = 0;
    gaps_on      = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) held[a] = '0;
    blk_left = 1;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset coefficients give zero out of any sample
    send_item(16'sh7fff, 16'sh8000, 16'sh5555, 1'b0);
    send_item(16'sh8000, 16'sh7fff, 16'shaaaa, 1'b1);

    // unit gain passes samples straight through, extremes included
    program_all(COEF_ONE, '0, '0, '0, '0);
    send_item(16'sh7fff, 16'sh8000, 16'sh0000, 1'b0);
    send_item(16'sh8000, 16'sh7fff, 16'shffff, 1'b1);
    send_item(16'sh0001, 16'shffff, 16'sh0000, 1'b0);
    send_item(16'sh0000, 16'sh0001, 16'sh7fff, 1'b1);

    // gain of eight drives the outputs into saturation both ways
    write_coef(COEF_B0, COEF_MAX);
    send_item(16'sh7fff, 16'sh8000, 16'sh1000, 1'b0);
    send_item(16'sh8000, 16'sh7fff, 16'she000, 1'b1);

    // gain of one half: rounding of exact halves goes up
    write_coef(COEF_B0, COEF_HALF);
    send_item(16'sh0001, 16'shffff, 16'sh0003, 1'b0);
    send_item(16'shfffd, 16'sh0002, 16'shfffe, 1'b1);

    // all coefficients at their extremes, feedback saturating hard
    program_all(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    send_item(16'sh7fff, 16'sh8000, 16'sh0001, 1'b0);
    send_item(16'sh8000, 16'sh7fff, 16'shffff, 1'b0);
    send_item(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
    send_item(16'sh1234, 16'shedcb, 16'sh4000, 1'b1);

    // a stable low pass, then writes past the last register: delays must survive
    program_all(COEF_W'(4426), COEF_W'(8852), COEF_W'(4426), COEF_W'(-74907),
                COEF_W'(27054));
    send_item(16'sh4000, 16'shc000, 16'sh7fff, 1'b0);
    send_item(16'sh4000, 16'shc000, 16'sh7fff, 1'b0);
    write_coef(FIRST_UNUSED_INDEX, COEF_MAX);
    send_item(16'sh4000, 16'shc000, 16'sh7fff, 1'b0);
    write_coef(LAST_UNUSED_INDEX, COEF_MIN);
    write_coef(CFG_INDEX_W'(NUM_COEFS + 1), COEF_ONE);
    send_item(16'sh4000, 16'shc000, 16'sh7fff, 1'b1);
    send_item(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);

    // random phases, each with its own coefficients and sample flavor
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      program_random_phase();
      phase_len = $urandom_range(20, 80);
      gaps_on   = ($urandom_range(0, 3) != 0);
      samp_mode = $urandom_range(0, 3);
      if (!hold_req) begin
        // first random phase: back-to-back items against the long receiver hold-off
        hold_req  <= 1'b1;
        gaps_on   = 1'b0;
        phase_len = 60;
      end
      repeat (phase_len) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          case (samp_mode)
            0: s[a] = SW'($urandom);
            1: s[a] = SW'($urandom_range(0, 1023)) - 16'sd512;   // low amplitude
            2: begin                                              // steps
              if ($urandom_range(0, 9) == 0) held[a] = SW'($urandom);
              s[a] = held[a];
            end
            default: begin
              case ($urandom_range(0, 4))
                0: s[a] = 16'sh7fff;
                1: s[a] = 16'sh8000;
                2: s[a] = 16'sh0001;
                3: s[a] = 16'shffff;
                default: s[a] = SW'($urandom);
              endcase
            end
          endcase
        end
        // mostly clean blocks of 1..16 triples, now and then a stray mark
        blk_left--;
        be = (blk_left == 0);
        if (blk_left == 0) blk_left = $urandom_range(1, 16);
        if ($urandom_range(0, 19) == 0) be = ~be;
        send_item(s[0], s[1], s[2], be);
      end
    end

    // drain, then let the pipeline settle before the verdict
    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (chk_fails == 0 && chk_pending == 0)
      $display("three_axis_biquad_filter verification clean");
    else
      $display("three_axis_biquad_filter verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/tabf_pkg.sv
sv/tabf_datapath.sv
sv/tabf_sequencer.sv
sv/three_axis_biquad_filter.sv
test/three_axis_biquad_filter_checker.sv
test/testbench.sv
